/* sv/pbm_pkg.sv */
// Package for the two-class packet buffer manager.
// Holds ring sizing constants, operation and status codes and pointer helpers.
// No dependencies.
package pbm_pkg;

  localparam int unsigned DEPTH    = 256;
  localparam int unsigned NumRings = 3;
  localparam int unsigned SlotW    = 8;
  localparam int unsigned OpW      = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned PtrW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW     = $clog2(DEPTH + 1);
  localparam int unsigned RingW    = $clog2(NumRings);
  localparam int unsigned RamDepth = NumRings * DEPTH;
  localparam int unsigned RamAddrW = $clog2(RamDepth);

  typedef logic [PtrW-1:0]     ptr_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [SlotW-1:0]    slot_t;
  typedef logic [RamAddrW-1:0] ram_addr_t;

  typedef enum logic [OpW-1:0] {
    OP_FREE_PUT  = 3'd0,
    OP_FREE_GET  = 3'd1,
    OP_AUDIO_PUT = 3'd2,
    OP_AUDIO_GET = 3'd3,
    OP_VIDEO_PUT = 3'd4,
    OP_VIDEO_GET = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [RingW-1:0] {
    RING_FREE  = 2'd0,
    RING_AUDIO = 2'd1,
    RING_VIDEO = 2'd2
  } ring_e;

  // Pointers wrap at DEPTH by comparison, so any depth works.
  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  function automatic ram_addr_t ring_addr(input ring_e ring, input ptr_t p);
    ram_addr_t base;
    base = ram_addr_t'(ring) * ram_addr_t'(DEPTH);
    return base + ram_addr_t'(p);
  endfunction

endpackage

/* sv/pbm_if.sv */
// Request and response channel interfaces of the packet buffer manager.
// Depends on pbm_pkg for the field widths.
interface pbm_req_if
  import pbm_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OpW-1:0]      opcode;
  logic [SlotW-1:0]    slot_index;

  modport source (output valid, output opcode, output slot_index, input ready);
  modport sink   (input valid, input opcode, input slot_index, output ready);
endinterface

interface pbm_rsp_if
  import pbm_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SlotW-1:0]    slot_out;
  logic [StatusW-1:0]  status;

  modport source (output valid, output slot_out, output status, input ready);
  modport sink   (input valid, input slot_out, input status, output ready);
endinterface

/* sv/pbm_ram.sv */
// Generic single-port synchronous RAM with a registered read port.
// Read data holds its value while no read is issued. No dependencies.
module pbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/packet_buffer_manager_two_class.sv */
// Top level of the two-class packet buffer manager.
// Depends on pbm_pkg, pbm_req_if, pbm_rsp_if and pbm_ram.
//
// The block keeps a free-slot ring and an audio and a video class ring in one
// shared single-port RAM, with head, tail and count registers per ring. Each
// request is one put or get, and the block takes one request per clock cycle
// while no response is stalled. At the accepting edge the ring RAM does its
// read and the request stage is loaded. The output register is loaded from the
// request stage when it is free or its response is taken. A stalled response
// holds the request stage and blocks new requests. Right after reset the free
// ring is full with slots 0 to DEPTH-1; no clearing pass is needed.
module packet_buffer_manager_two_class
  import pbm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pbm_req_if.sink   req_i,
  pbm_rsp_if.source rsp_o
);

  ptr_t  head_q [NumRings];
  ptr_t  tail_q [NumRings];
  cnt_t  cnt_q  [NumRings];
  logic  [DEPTH-1:0] free_vld_q;

  ring_e ring;
  logic  is_put;
  logic  op_ok;
  cnt_t  cnt;
  logic  full;
  logic  empty;
  logic  accept;
  logic  do_put;
  logic  do_get;
  slot_t rdata;

  logic    s1_vld_q;
  logic    s1_get_q;
  logic    s1_ram_q;
  slot_t   s1_fallback_q;
  status_e s1_status_q;
  status_e status_d;
  logic    s1_adv;

  logic    out_vld_q;
  slot_t   out_slot_q;
  status_e out_status_q;
  slot_t   out_slot_d;

  always_comb begin
    ring   = RING_FREE;
    is_put = 1'b0;
    op_ok  = 1'b1;
    unique case (op_e'(req_i.opcode))
      OP_FREE_PUT:  begin ring = RING_FREE;  is_put = 1'b1; end
      OP_FREE_GET:  begin ring = RING_FREE;  is_put = 1'b0; end
      OP_AUDIO_PUT: begin ring = RING_AUDIO; is_put = 1'b1; end
      OP_AUDIO_GET: begin ring = RING_AUDIO; is_put = 1'b0; end
      OP_VIDEO_PUT: begin ring = RING_VIDEO; is_put = 1'b1; end
      OP_VIDEO_GET: begin ring = RING_VIDEO; is_put = 1'b0; end
      default:      op_ok = 1'b0;
    endcase
  end

  assign cnt    = cnt_q[ring];
  assign full   = (cnt == cnt_t'(DEPTH));
  assign empty  = (cnt == '0);
  assign s1_adv = s1_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !s1_vld_q || s1_adv;
  assign accept = req_i.valid && req_i.ready;
  assign do_put = accept && op_ok && is_put && !full;
  assign do_get = accept && op_ok && !is_put && !empty;

  always_comb begin
    status_d = ST_OK;
    if (op_ok && is_put && full) begin
      status_d = ST_FULL;
    end else if (op_ok && !is_put && empty) begin
      status_d = ST_EMPTY;
    end
  end

  pbm_ram #(
    .Width (SlotW),
    .Depth (RamDepth)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .en_i    (do_put || do_get),
    .we_i    (do_put),
    .addr_i  (ring_addr(ring, is_put ? tail_q[ring] : head_q[ring])),
    .wdata_i (req_i.slot_index),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRings; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= (i == int'(RING_FREE)) ? cnt_t'(DEPTH) : '0;
      end
      free_vld_q <= '0;
    end else begin
      if (do_put) begin
        tail_q[ring] <= ptr_next(tail_q[ring]);
        cnt_q[ring]  <= cnt + cnt_t'(1);
        if (ring == RING_FREE) begin
          free_vld_q[tail_q[ring]] <= 1'b1;
        end
      end
      if (do_get) begin
        head_q[ring] <= ptr_next(head_q[ring]);
        cnt_q[ring]  <= cnt - cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // A free ring entry that was never written still holds its own index.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_get_q      <= do_get;
      s1_ram_q      <= (ring != RING_FREE) || free_vld_q[head_q[ring]];
      s1_fallback_q <= slot_t'(head_q[ring]);
      s1_status_q   <= status_d;
    end
  end

  always_comb begin
    out_slot_d = '0;
    if (s1_get_q) begin
      out_slot_d = s1_ram_q ? rdata : s1_fallback_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_slot_q   <= out_slot_d;
      out_status_q <= s1_status_q;
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.slot_out = out_slot_q;
  assign rsp_o.status   = out_status_q;

endmodule

/* tb/sv/tb_packet_buffer_manager_two_class.sv */
// Self-checking testbench for the two-class packet buffer manager.
// Sends put and get requests, predicts each response with a ring model and checks it.
// Depends on pbm_pkg, pbm_req_if, pbm_rsp_if and packet_buffer_manager_two_class.
module tb_packet_buffer_manager_two_class;
  import pbm_pkg::*;

  localparam logic [OpW-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OpW-1:0] OP_UNUSED_HI = 3'd7;
  localparam int unsigned    QuietLimit   = 2000;
  localparam int unsigned    SettleCycles = 8;
  localparam int unsigned    MaxReports   = 10;

  typedef struct packed {
    slot_t   slot;
    status_e status;
  } slot_grant_t;

  logic clk_i;
  logic rst_ni;

  pbm_req_if req_bus ();
  pbm_rsp_if rsp_bus ();

  packet_buffer_manager_two_class uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  slot_t       ring_store [NumRings][DEPTH];
  ptr_t        ring_head  [NumRings];
  ptr_t        ring_tail  [NumRings];
  int unsigned ring_fill  [NumRings];

  slot_grant_t awaited_grants [$];
  slot_grant_t last_grant;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left;
  bit          idling_on;

  always #1 clk_i = ~clk_i;

  function automatic status_e ring_push(input ring_e ring, input slot_t value);
    if (ring_fill[ring] >= DEPTH) return ST_FULL;
    ring_store[ring][ring_tail[ring]] = value;
    ring_tail[ring] = (ring_tail[ring] == ptr_t'(DEPTH - 1)) ? ptr_t'(0)
                                                             : ring_tail[ring] + ptr_t'(1);
    ring_fill[ring]++;
    return ST_OK;
  endfunction

  function automatic status_e ring_pop(input ring_e ring, output slot_t value);
    value = '0;
    if (ring_fill[ring] == 0) return ST_EMPTY;
    value = ring_store[ring][ring_head[ring]];
    ring_head[ring] = (ring_head[ring] == ptr_t'(DEPTH - 1)) ? ptr_t'(0)
                                                             : ring_head[ring] + ptr_t'(1);
    ring_fill[ring]--;
    return ST_OK;
  endfunction

  function automatic slot_grant_t predict_grant(input logic [OpW-1:0] op, input slot_t index);
    slot_grant_t grant;
    grant.slot   = '0;
    grant.status = ST_OK;
    case (op)
      OP_FREE_PUT:  grant.status = ring_push(RING_FREE, index);
      OP_FREE_GET:  grant.status = ring_pop(RING_FREE, grant.slot);
      OP_AUDIO_PUT: grant.status = ring_push(RING_AUDIO, index);
      OP_AUDIO_GET: grant.status = ring_pop(RING_AUDIO, grant.slot);
      OP_VIDEO_PUT: grant.status = ring_push(RING_VIDEO, index);
      OP_VIDEO_GET: grant.status = ring_pop(RING_VIDEO, grant.slot);
      default: ;
    endcase
    return grant;
  endfunction

  task automatic report_mismatch(input string what, input logic [SlotW-1:0] want,
                                 input logic [SlotW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("mismatch in %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Ready only changes at rising edges, so it is sampled at the falling edge.
  task automatic send_request(input logic [OpW-1:0] op, input slot_t index,
                              output slot_grant_t grant);
    logic taken;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.opcode     <= op;
    req_bus.slot_index <= index;
    do begin
      @(negedge clk_i);
      taken = req_bus.ready;
      @(posedge clk_i);
    end while (!taken);
    grant = predict_grant(op, index);
    awaited_grants.push_back(grant);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_grants.size() != 0);
  endtask

  task automatic put_until_full(input logic [OpW-1:0] op);
    int unsigned full_seen;
    full_seen = 0;
    while (full_seen < 2) begin
      send_request(op, slot_t'($urandom), last_grant);
      if (last_grant.status == ST_FULL) full_seen++;
    end
  endtask

  task automatic test_directed_cases();
    idling_on = 1'b0;
    send_request(OP_FREE_PUT,  8'hFF, last_grant);
    send_request(OP_AUDIO_GET, 8'h5A, last_grant);
    send_request(OP_VIDEO_GET, 8'hA5, last_grant);
    send_request(OP_FREE_GET,  8'h00, last_grant);
    send_request(OP_FREE_GET,  8'hFF, last_grant);
    send_request(OP_AUDIO_PUT, 8'h00, last_grant);
    send_request(OP_AUDIO_PUT, 8'hFF, last_grant);
    send_request(OP_VIDEO_PUT, 8'hFF, last_grant);
    send_request(OP_VIDEO_PUT, 8'h00, last_grant);
    send_request(OP_AUDIO_GET, 8'hFF, last_grant);
    send_request(OP_VIDEO_GET, 8'h00, last_grant);
    send_request(OP_UNUSED_LO, 8'hFF, last_grant);
    send_request(OP_UNUSED_HI, 8'h00, last_grant);
    send_request(OP_FREE_PUT,  8'h00, last_grant);
    send_request(OP_FREE_GET,  8'hFF, last_grant);
    wait_drained();
  endtask

  task automatic test_audio_overflow();
    idling_on = 1'b1;
    put_until_full(OP_AUDIO_PUT);
    wait_drained();
  endtask

  // Moves every free slot into the video ring, then overfills it.
  task automatic test_video_from_free_pool();
    int unsigned empty_seen;
    empty_seen = 0;
    idling_on  = 1'b1;
    while (empty_seen < 2) begin
      send_request(OP_FREE_GET, slot_t'($urandom), last_grant);
      if (last_grant.status == ST_EMPTY) begin
        empty_seen++;
      end else begin
        send_request(OP_VIDEO_PUT, last_grant.slot, last_grant);
      end
    end
    put_until_full(OP_VIDEO_PUT);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned steps, input bit with_idling);
    int unsigned      pick;
    logic [OpW-1:0]   class_put;
    logic [OpW-1:0]   class_get;
    logic [OpW-1:0]   noise_op;
    idling_on = with_idling;
    repeat (steps) begin
      pick      = $urandom_range(0, 9);
      class_put = $urandom_range(0, 1) ? OP_AUDIO_PUT : OP_VIDEO_PUT;
      class_get = $urandom_range(0, 1) ? OP_AUDIO_GET : OP_VIDEO_GET;
      noise_op  = OpW'($urandom_range(0, 7));
      if (pick < 4) begin
        send_request(OP_FREE_GET, slot_t'($urandom), last_grant);
        if (last_grant.status == ST_OK) send_request(class_put, last_grant.slot, last_grant);
      end else if (pick < 8) begin
        send_request(class_get, slot_t'($urandom), last_grant);
        if (last_grant.status == ST_OK) send_request(OP_FREE_PUT, last_grant.slot, last_grant);
      end else begin
        send_request(noise_op, slot_t'($urandom), last_grant);
      end
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left    <= 0;
      rsp_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      rsp_bus.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(0, 6);
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_grants
    slot_grant_t expected;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (awaited_grants.size() == 0) begin
        report_mismatch("unrequested response slot_out", '0, rsp_bus.slot_out);
      end else begin
        expected = awaited_grants.pop_front();
        if (rsp_bus.slot_out !== expected.slot) begin
          report_mismatch("slot_out", expected.slot, rsp_bus.slot_out);
        end
        if (rsp_bus.status !== expected.status) begin
          report_mismatch("status", SlotW'(expected.status), SlotW'(rsp_bus.status));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      if (quiet_cycles >= QuietLimit) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.opcode     = OP_FREE_PUT;
    req_bus.slot_index = '0;
    idling_on          = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      ring_store[RING_FREE][i] = slot_t'(i);
    end
    for (int r = 0; r < NumRings; r++) begin
      ring_head[r] = '0;
      ring_tail[r] = '0;
      ring_fill[r] = 0;
    end
    ring_fill[RING_FREE] = DEPTH;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_audio_overflow();
    test_video_from_free_pool();
    test_random_traffic(60, 1'b1);
    test_random_traffic(40, 1'b0);

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_grants.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
